@@ rtl/lvn_pkg.sv @@
// Shared widths and hash constants for the 2D lattice value noise pipeline.
`default_nettype none
package lvn_pkg;

    localparam int COORD_W   = 32;
    localparam int HASH_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int OUT_BITS  = 16;
    localparam int INT_BITS  = COORD_W - FRAC_BITS;
    localparam int S_DATA_W  = 2 * COORD_W;
    localparam int M_DATA_W  = 16;

    // hash multipliers and offsets
    localparam logic [HASH_W-1:0] HASH_MUL_X    = 32'd374761393;
    localparam logic [HASH_W-1:0] HASH_MUL_Y    = 32'd668265263;
    localparam logic [HASH_W-1:0] HASH_MUL_SEED = 32'd982451653;
    localparam logic [HASH_W-1:0] HASH_MUL_SQ   = 32'd60493;
    localparam logic [HASH_W-1:0] HASH_ADD_SQ   = 32'd19990303;
    localparam logic [HASH_W-1:0] HASH_ADD_OUT  = 32'd1376312589;
    localparam logic [HASH_W-1:0] HASH_MUL_XY   = HASH_MUL_X + HASH_MUL_Y;
    localparam int                HASH_SHIFT    = 13;

    typedef logic [HASH_W-1:0]    hash_t;
    typedef logic [FRAC_BITS-1:0] frac_t;
    typedef logic [OUT_BITS-1:0]  value_t;

endpackage
`default_nettype wire

@@ rtl/lvn_hash.sv @@
// One lattice corner hash: xorshift, square, polynomial, final multiply, four stages.
`default_nettype none
module lvn_hash (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire lvn_pkg::hash_t   n_in,
    output lvn_pkg::value_t       value_out
);
    import lvn_pkg::*;

    hash_t  m1_reg, m1_next;
    hash_t  m2_reg;
    hash_t  m3_reg;
    hash_t  sq_reg, sq_next;
    hash_t  t_reg, t_next;
    hash_t  h_next;
    value_t val_reg;

    always_comb begin
        m1_next = {{HASH_SHIFT{n_in[HASH_W-1]}}, n_in[HASH_W-1:HASH_SHIFT]} ^ n_in;
        sq_next = m1_reg * m1_reg;
        t_next  = sq_reg * HASH_MUL_SQ + HASH_ADD_SQ;
        h_next  = m3_reg * t_reg + HASH_ADD_OUT;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg  <= m1_next;
            m2_reg  <= m1_reg;
            sq_reg  <= sq_next;
            m3_reg  <= m2_reg;
            t_reg   <= t_next;
            // drop the sign bit, keep the top bits of the 31-bit hash
            val_reg <= h_next[HASH_W-2 -: OUT_BITS];
        end
    end

    assign value_out = val_reg;

endmodule
`default_nettype wire

@@ rtl/lvn_ease.sv @@
// Smoothstep t*t*(3-2t) of a fraction, two stages.
`default_nettype none
module lvn_ease (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire lvn_pkg::frac_t f_in,
    output lvn_pkg::frac_t      s_out
);
    import lvn_pkg::*;

    logic [2*FRAC_BITS-1:0]   sq;
    frac_t                    t2_reg;
    logic [FRAC_BITS+1:0]     w_reg, w_next;
    logic [2*FRAC_BITS+1:0]   prod;
    frac_t                    s_reg;

    always_comb begin
        sq     = {{FRAC_BITS{1'b0}}, f_in} * {{FRAC_BITS{1'b0}}, f_in};
        w_next = (FRAC_BITS+2)'(3 << FRAC_BITS) - {1'b0, f_in, 1'b0};
        prod   = {{(FRAC_BITS+2){1'b0}}, t2_reg} * {{FRAC_BITS{1'b0}}, w_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg <= sq[2*FRAC_BITS-1:FRAC_BITS];
            w_reg  <= w_next;
            // smoothstep stays below one, so the upper bits are zero
            s_reg  <= prod[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    assign s_out = s_reg;

endmodule
`default_nettype wire

@@ rtl/lvn_blend.sv @@
// Registered linear blend a + floor((b-a)*s / 2^F).
`default_nettype none
module lvn_blend (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire lvn_pkg::value_t a_in,
    input  wire lvn_pkg::value_t b_in,
    input  wire lvn_pkg::frac_t  s_in,
    output lvn_pkg::value_t      n_out
);
    import lvn_pkg::*;

    logic signed [OUT_BITS:0]            diff;
    logic signed [OUT_BITS+FRAC_BITS+1:0] prod;
    logic signed [OUT_BITS+FRAC_BITS+1:0] quot;
    value_t                               n_reg, n_next;

    always_comb begin
        diff   = $signed({1'b0, b_in}) - $signed({1'b0, a_in});
        prod   = $signed({{(FRAC_BITS+1){diff[OUT_BITS]}}, diff})
               * $signed({{(OUT_BITS+2){1'b0}}, s_in});
        quot   = prod >>> FRAC_BITS;
        // exact result lies between a and b, so modulo arithmetic is safe
        n_next = a_in + quot[OUT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
        end
    end

    assign n_out = n_reg;

endmodule
`default_nettype wire

@@ rtl/lattice_value_noise_2d.sv @@
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output register is full and m_tready is low.
// Reset: aresetn (synchronous, active low) clears all valid bits and the seed to 0.
// Stages: lattice products, corner sum/xorshift, square, polynomial, final hash
// multiply, row blends, column blend.
`default_nettype none
module lattice_value_noise_2d (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lvn_pkg::HASH_W-1:0]  cfg_wr_data,  // noise_seed
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [lvn_pkg::S_DATA_W-1:0] s_tdata,     // [31:0] x_coord, [63:32] y_coord
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [lvn_pkg::M_DATA_W-1:0]     m_tdata       // [15:0] noise_value
);
    import lvn_pkg::*;

    localparam int DEPTH = 7;

    logic               en;
    logic [DEPTH-1:0]   v_reg, v_next;
    hash_t              seed_reg;

    logic signed [COORD_W-1:0] x_in, y_in;
    hash_t              xi, yi;
    hash_t              xa_reg, yb_reg, sc_reg;
    frac_t              fx_reg, fy_reg;
    hash_t              base;
    hash_t              n00, n10, n01, n11;
    value_t             v00, v10, v01, v11;
    frac_t              sx, sy;
    frac_t              sx4_reg, sx5_reg;
    frac_t              sy4_reg, sy5_reg, sy6_reg;
    value_t             row0, row1, res;

    assign en       = !v_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign v_next   = {v_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            seed_reg <= '0;
        end else begin
            if (en) begin
                v_reg <= v_next;
            end
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // stage 1: floor to lattice cell and the per-axis hash products
    always_comb begin
        x_in = $signed(s_tdata[COORD_W-1:0]);
        y_in = $signed(s_tdata[2*COORD_W-1:COORD_W]);
        xi   = x_in >>> FRAC_BITS;
        yi   = y_in >>> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg <= xi * HASH_MUL_X;
            yb_reg <= yi * HASH_MUL_Y;
            sc_reg <= seed_reg * HASH_MUL_SEED;
            fx_reg <= s_tdata[FRAC_BITS-1:0];
            fy_reg <= s_tdata[COORD_W+FRAC_BITS-1:COORD_W];
        end
    end

    // corner +1 steps fold into constant offsets of the product sum
    always_comb begin
        base = xa_reg + yb_reg + sc_reg;
        n00  = base;
        n10  = base + HASH_MUL_X;
        n01  = base + HASH_MUL_Y;
        n11  = base + HASH_MUL_XY;
    end

    lvn_hash u_hash00 (.aclk(aclk), .en(en), .n_in(n00), .value_out(v00));
    lvn_hash u_hash10 (.aclk(aclk), .en(en), .n_in(n10), .value_out(v10));
    lvn_hash u_hash01 (.aclk(aclk), .en(en), .n_in(n01), .value_out(v01));
    lvn_hash u_hash11 (.aclk(aclk), .en(en), .n_in(n11), .value_out(v11));

    lvn_ease u_ease_x (.aclk(aclk), .en(en), .f_in(fx_reg), .s_out(sx));
    lvn_ease u_ease_y (.aclk(aclk), .en(en), .f_in(fy_reg), .s_out(sy));

    // line the eased weights up with the corner values
    always_ff @(posedge aclk) begin
        if (en) begin
            sx4_reg <= sx;
            sx5_reg <= sx4_reg;
            sy4_reg <= sy;
            sy5_reg <= sy4_reg;
            sy6_reg <= sy5_reg;
        end
    end

    lvn_blend u_blend_row0 (
        .aclk(aclk), .en(en), .a_in(v00), .b_in(v10), .s_in(sx5_reg), .n_out(row0)
    );
    lvn_blend u_blend_row1 (
        .aclk(aclk), .en(en), .a_in(v01), .b_in(v11), .s_in(sx5_reg), .n_out(row1)
    );
    lvn_blend u_blend_col (
        .aclk(aclk), .en(en), .a_in(row0), .b_in(row1), .s_in(sy6_reg), .n_out(res)
    );

    assign m_tvalid = v_reg[DEPTH-1];
    assign m_tdata  = M_DATA_W'(res);

endmodule
`default_nettype wire
